// ===== rtl/dvc_pkg.sv =====
`timescale 1ns / 1ps

package dvc_pkg;

  localparam int unsigned PosW   = 31;
  localparam int unsigned HeadW  = 16;
  localparam int unsigned CfgW   = 24;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned SpeedW = 25;
  localparam int unsigned StatW  = 2;
  localparam int unsigned DiffW  = 32;
  localparam int unsigned SumW   = 64;
  localparam int unsigned RootW  = 32;
  localparam int unsigned OpW    = 33;
  localparam int unsigned ProdW  = 2 * OpW;

  // Register indexes of the configuration port.
  localparam logic [CfgIdxW-1:0] RegGain     = 2'd0;
  localparam logic [CfgIdxW-1:0] RegMaxSpeed = 2'd1;
  localparam logic [CfgIdxW-1:0] RegMinSpeed = 2'd2;
  localparam logic [CfgIdxW-1:0] RegStopTol  = 2'd3;

  // Reset values: 0.1, 0.2 m/s, 0.05 m/s and 0.01 m in unsigned Q8.16.
  localparam logic [CfgW-1:0] GainReset     = 24'd6554;
  localparam logic [CfgW-1:0] MaxSpeedReset = 24'd13107;
  localparam logic [CfgW-1:0] MinSpeedReset = 24'd3277;
  localparam logic [CfgW-1:0] StopTolReset  = 24'd655;

  localparam logic [StatW-1:0] StatusMoving  = 2'd0;
  localparam logic [StatW-1:0] StatusReached = 2'd1;
  localparam logic [StatW-1:0] StatusOscStop = 2'd2;

endpackage

// ===== rtl/dvc_if.sv =====
`timescale 1ns / 1ps

interface dvc_in_if;
  logic                              valid;
  logic                              ready;
  logic signed [dvc_pkg::PosW-1:0]   robot_x;
  logic signed [dvc_pkg::PosW-1:0]   robot_y;
  logic signed [dvc_pkg::HeadW-1:0]  heading_cos;
  logic signed [dvc_pkg::HeadW-1:0]  heading_sin;
  logic signed [dvc_pkg::PosW-1:0]   goal_x;
  logic signed [dvc_pkg::PosW-1:0]   goal_y;

  modport source (output valid, robot_x, robot_y, heading_cos, heading_sin, goal_x, goal_y,
                  input ready);
  modport sink (input valid, robot_x, robot_y, heading_cos, heading_sin, goal_x, goal_y,
                output ready);
endinterface

interface dvc_out_if;
  logic                               valid;
  logic                               ready;
  logic signed [dvc_pkg::SpeedW-1:0]  linear_speed;
  logic [dvc_pkg::StatW-1:0]          status;

  modport source (output valid, linear_speed, status, input ready);
  modport sink (input valid, linear_speed, status, output ready);
endinterface

// ===== rtl/dvc_mul.sv =====
`timescale 1ns / 1ps

// Shared signed multiplier with a registered product.
module dvc_mul (
  input  logic                               clk_i,
  input  logic signed [dvc_pkg::OpW-1:0]     a_i,
  input  logic signed [dvc_pkg::OpW-1:0]     b_i,
  output logic signed [dvc_pkg::ProdW-1:0]   prod_o
);

  logic signed [dvc_pkg::ProdW-1:0] prod_q;

  always_ff @(posedge clk_i) begin
    prod_q <= a_i * b_i;
  end

  assign prod_o = prod_q;

endmodule

// ===== rtl/dvc_isqrt.sv =====
`timescale 1ns / 1ps

// Bit-pair restoring integer square root, one result bit per cycle.
module dvc_isqrt (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [dvc_pkg::SumW-1:0]      radicand_i,
  output logic                          done_o,
  output logic [dvc_pkg::RootW-1:0]     root_o
);

  localparam int unsigned CntW = $clog2(dvc_pkg::RootW);
  localparam logic [dvc_pkg::SumW-1:0] TopBit =
    {2'b01, {(dvc_pkg::SumW - 2){1'b0}}};

  logic [dvc_pkg::SumW-1:0] rem_q;
  logic [dvc_pkg::SumW-1:0] res_q;
  logic [dvc_pkg::SumW-1:0] bit_q;
  logic [CntW-1:0]          cnt_q;
  logic                     busy_q;
  logic                     done_q;
  logic [dvc_pkg::SumW-1:0] trial;

  assign trial = res_q + bit_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
        rem_q  <= radicand_i;
        res_q  <= '0;
        bit_q  <= TopBit;
      end else if (busy_q) begin
        if (rem_q >= trial) begin
          rem_q <= rem_q - trial;
          res_q <= (res_q >> 1) + bit_q;
        end else begin
          res_q <= res_q >> 1;
        end
        bit_q <= bit_q >> 2;
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CntW'(dvc_pkg::RootW - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign done_o = done_q;
  assign root_o = res_q[dvc_pkg::RootW-1:0];

endmodule

// ===== rtl/dock_approach_velocity_control_unit.sv =====
`timescale 1ns / 1ps

// The 32-step square root dominates the time from an accepted request to its result.
// A new request is taken only once the previous result sits in the output register,
// and a full output register stalls only the final step.
// The shared 33x33 multiplier handles the squares, the heading projection and the gain.
// Reset (asynchronous, active low) loads the default configuration and clears the previous direction.
module dock_approach_velocity_control_unit (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  dvc_in_if.sink                            in_req,
  dvc_out_if.source                         out_rsp,
  input  logic                              cfg_we_i,
  input  logic [dvc_pkg::CfgIdxW-1:0]       cfg_idx_i,
  input  logic [dvc_pkg::CfgW-1:0]          cfg_wdata_i
);

  typedef enum logic [3:0] {
    StIdle, StSqX, StSqY, StProjX, StProjY, StProjSum, StSqrt, StGain, StDecide
  } state_e;

  localparam int unsigned OpW  = dvc_pkg::OpW;
  localparam int unsigned PW   = 40;  // width of gain * d >> 16
  localparam int unsigned VW   = PW + 2;

  state_e state_q, state_d;

  logic [dvc_pkg::CfgW-1:0] gain_q, max_speed_q, min_speed_q, stop_tol_q;
  logic prev_pos_q, prev_neg_q;

  logic signed [dvc_pkg::DiffW-1:0] dx_q, dy_q;
  logic [dvc_pkg::DiffW-1:0]        adx_q, ady_q;
  logic signed [dvc_pkg::HeadW-1:0] hc_q, hs_q;
  logic [dvc_pkg::SumW-1:0]         sum_q;
  logic signed [dvc_pkg::SumW-1:0]  proj_q;
  logic [dvc_pkg::RootW-1:0]        d_q;

  logic                             out_valid_q;
  logic signed [dvc_pkg::SpeedW-1:0] speed_q;
  logic [dvc_pkg::StatW-1:0]        status_q;

  logic signed [dvc_pkg::DiffW-1:0] dx_in, dy_in;
  logic signed [OpW-1:0]            op_a, op_b;
  logic signed [dvc_pkg::ProdW-1:0] prod;
  logic                             sqrt_done;
  logic [dvc_pkg::RootW-1:0]        root;

  logic                             out_free;
  logic [PW-1:0]                    p;
  logic signed [VW-1:0]             v_ahead;
  logic                             ahead, behind, reached, osc;
  logic signed [dvc_pkg::SpeedW-1:0] speed_new;
  logic [dvc_pkg::StatW-1:0]        status_new;

  assign dx_in = dvc_pkg::DiffW'(in_req.goal_x) - dvc_pkg::DiffW'(in_req.robot_x);
  assign dy_in = dvc_pkg::DiffW'(in_req.goal_y) - dvc_pkg::DiffW'(in_req.robot_y);

  // Operand selection for the shared multiplier.
  always_comb begin
    op_a = '0;
    op_b = '0;
    case (state_q)
      StSqX: begin
        op_a = $signed({1'b0, adx_q});
        op_b = $signed({1'b0, adx_q});
      end
      StSqY: begin
        op_a = $signed({1'b0, ady_q});
        op_b = $signed({1'b0, ady_q});
      end
      StProjX: begin
        op_a = OpW'(dx_q);
        op_b = OpW'(hc_q);
      end
      StProjY: begin
        op_a = OpW'(dy_q);
        op_b = OpW'(hs_q);
      end
      // The gain operands stay applied while the result waits for the output register.
      StGain, StDecide: begin
        op_a = $signed({{(OpW - dvc_pkg::CfgW){1'b0}}, gain_q});
        op_b = $signed({1'b0, d_q});
      end
      default: begin
        op_a = '0;
        op_b = '0;
      end
    endcase
  end

  dvc_mul u_mul (
    .clk_i  (clk_i),
    .a_i    (op_a),
    .b_i    (op_b),
    .prod_o (prod)
  );

  dvc_isqrt u_isqrt (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (state_q == StProjY),
    .radicand_i (sum_q),
    .done_o     (sqrt_done),
    .root_o     (root)
  );

  // Final decision, using the gain product that lands in the decide step.
  always_comb begin
    p        = prod[PW+15:16];
    ahead    = (proj_q > 0);
    behind   = (proj_q < 0);
    reached  = (d_q < dvc_pkg::RootW'(stop_tol_q));
    osc      = (d_q == '0) || !(ahead || behind) || (ahead && prev_neg_q)
               || (behind && prev_pos_q);
    v_ahead  = $signed({2'b00, PW'(max_speed_q)}) - $signed({2'b00, p});
    speed_new  = '0;
    status_new = dvc_pkg::StatusMoving;
    if (reached) begin
      status_new = dvc_pkg::StatusReached;
    end else if (osc) begin
      status_new = dvc_pkg::StatusOscStop;
    end else if (ahead) begin
      if (v_ahead <= $signed({{(VW - dvc_pkg::CfgW){1'b0}}, min_speed_q})) begin
        speed_new = $signed({1'b0, min_speed_q});
      end else begin
        speed_new = v_ahead[dvc_pkg::SpeedW-1:0];
      end
    end else if (gain_q == '0) begin
      speed_new = '0;
    end else if (p > PW'(max_speed_q)) begin
      speed_new = -$signed({1'b0, max_speed_q});
    end else if (p < PW'(min_speed_q)) begin
      speed_new = -$signed({1'b0, min_speed_q});
    end else begin
      speed_new = -$signed({1'b0, p[dvc_pkg::CfgW-1:0]});
    end
  end

  assign out_free = !out_valid_q || out_rsp.ready;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle:    if (in_req.valid) state_d = StSqX;
      StSqX:     state_d = StSqY;
      StSqY:     state_d = StProjX;
      StProjX:   state_d = StProjY;
      StProjY:   state_d = StProjSum;
      StProjSum: state_d = StSqrt;
      StSqrt:    if (sqrt_done) state_d = StGain;
      StGain:    state_d = StDecide;
      StDecide:  if (out_free) state_d = StIdle;
      default:   state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      gain_q      <= dvc_pkg::GainReset;
      max_speed_q <= dvc_pkg::MaxSpeedReset;
      min_speed_q <= dvc_pkg::MinSpeedReset;
      stop_tol_q  <= dvc_pkg::StopTolReset;
      prev_pos_q  <= 1'b0;
      prev_neg_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          dvc_pkg::RegGain:     gain_q      <= cfg_wdata_i;
          dvc_pkg::RegMaxSpeed: max_speed_q <= cfg_wdata_i;
          dvc_pkg::RegMinSpeed: min_speed_q <= cfg_wdata_i;
          dvc_pkg::RegStopTol:  stop_tol_q  <= cfg_wdata_i;
          default: ;
        endcase
      end
      if (state_q == StDecide && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_rsp.ready) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        StIdle: begin
          if (in_req.valid) begin
            dx_q  <= dx_in;
            dy_q  <= dy_in;
            adx_q <= dx_in[dvc_pkg::DiffW-1] ? -dx_in : dx_in;
            ady_q <= dy_in[dvc_pkg::DiffW-1] ? -dy_in : dy_in;
            hc_q  <= in_req.heading_cos;
            hs_q  <= in_req.heading_sin;
          end
        end
        StSqY:     sum_q  <= prod[dvc_pkg::SumW-1:0];
        StProjX:   sum_q  <= sum_q + prod[dvc_pkg::SumW-1:0];
        StProjY:   proj_q <= prod[dvc_pkg::SumW-1:0];
        StProjSum: proj_q <= proj_q + prod[dvc_pkg::SumW-1:0];
        StSqrt:    if (sqrt_done) d_q <= root;
        StDecide: begin
          if (out_free) begin
            speed_q     <= speed_new;
            status_q    <= status_new;
            // Any stop forgets the previous direction.
            if (reached || osc) begin
              prev_pos_q <= 1'b0;
              prev_neg_q <= 1'b0;
            end else begin
              prev_pos_q <= ahead;
              prev_neg_q <= behind;
            end
          end
        end
        default: ;
      endcase
    end
  end

  assign in_req.ready         = (state_q == StIdle);
  assign out_rsp.valid        = out_valid_q;
  assign out_rsp.linear_speed = speed_q;
  assign out_rsp.status       = status_q;

endmodule

// ===== verif/dock_approach_velocity_control_unit_test.sv =====
`timescale 1ns / 1ps

module dock_approach_velocity_control_unit_test;
  import dvc_pkg::*;

  localparam longint Meter = 65536;
  localparam longint HeadOne = 16384;
  localparam longint PosMax = (longint'(1) << (PosW - 1)) - 1;
  localparam longint PosMin = -PosMax - 1;
  localparam int CycleLimit = 600000;
  localparam int SegmentItems = 92;

  typedef struct {
    logic signed [PosW-1:0]  robot_x;
    logic signed [PosW-1:0]  robot_y;
    logic signed [HeadW-1:0] heading_cos;
    logic signed [HeadW-1:0] heading_sin;
    logic signed [PosW-1:0]  goal_x;
    logic signed [PosW-1:0]  goal_y;
  } pose_t;

  typedef struct {
    logic signed [SpeedW-1:0] speed;
    logic [StatW-1:0]         status;
  } speed_cmd_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we;
  logic [CfgIdxW-1:0] cfg_idx;
  logic [CfgW-1:0] cfg_wdata;
  logic rsp_ready = 1'b0;
  int stall_left = 0;
  int tx_idle_pct;
  int rx_idle_pct;
  int cycle_count = 0;
  int fail_count = 0;

  // Predictor state: register copies and the last moving signed distance.
  logic [CfgW-1:0] kp_gain;
  logic [CfgW-1:0] speed_max;
  logic [CfgW-1:0] speed_min;
  logic [CfgW-1:0] reach_tol;
  logic signed [33:0] last_signed_span;

  speed_cmd_t expected_cmds[$];

  dvc_in_if in_req();
  dvc_out_if out_rsp();

  assign out_rsp.ready = rsp_ready;

  dock_approach_velocity_control_unit uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_req     (in_req),
    .out_rsp    (out_rsp),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_wdata_i(cfg_wdata)
  );

  always #6 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("tb: failure");
      $finish;
    end
  end

  // Receiver stalls come in short runs with an occasional long one.
  always @(posedge clk_i) begin
    if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      rsp_ready <= 1'b0;
    end else if ($urandom_range(99) < rx_idle_pct) begin
      stall_left <= ($urandom_range(7) == 0) ? $urandom_range(5, 60) : $urandom_range(0, 2);
      rsp_ready <= 1'b0;
    end else begin
      rsp_ready <= 1'b1;
    end
  end

  function automatic void log_failure(string msg);
    fail_count++;
    if (fail_count <= 10) $display("%0t: %s", $time, msg);
  endfunction

  function automatic logic [31:0] floor_root(logic [63:0] n);
    logic [31:0] root;
    logic [31:0] trial;
    root = '0;
    for (int b = 31; b >= 0; b--) begin
      trial = root | (32'd1 << b);
      if ({32'd0, trial} * {32'd0, trial} <= n) root = trial;
    end
    return root;
  endfunction

  // Advances the predictor by one pose and returns the command it should produce.
  function automatic speed_cmd_t compute_speed_command(pose_t p);
    longint dx;
    longint dy;
    longint proj;
    longint sspan;
    longint push;
    longint v;
    logic [63:0] span_sq;
    logic [31:0] span;
    speed_cmd_t cmd;
    dx = longint'(p.goal_x) - longint'(p.robot_x);
    dy = longint'(p.goal_y) - longint'(p.robot_y);
    span_sq = $unsigned(dx * dx) + $unsigned(dy * dy);
    span = floor_root(span_sq);
    proj = dx * longint'(p.heading_cos) + dy * longint'(p.heading_sin);
    sspan = (proj > 0) ? longint'(span) : (proj < 0) ? -longint'(span) : 0;
    cmd.speed = '0;
    if (span < reach_tol) begin
      last_signed_span = '0;
      cmd.status = StatusReached;
      return cmd;
    end
    if (sspan == 0 || (sspan > 0 && last_signed_span < 0) ||
        (sspan < 0 && last_signed_span > 0)) begin
      last_signed_span = '0;
      cmd.status = StatusOscStop;
      return cmd;
    end
    last_signed_span = 34'(sspan);
    push = longint'(({40'd0, kp_gain} * {32'd0, span}) >> 16);
    if (sspan > 0) begin
      v = longint'(speed_max) - push;
      if (v <= longint'(speed_min)) v = longint'(speed_min);
    end else if (kp_gain == '0) begin
      v = 0;
    end else if (push > longint'(speed_max)) begin
      v = -longint'(speed_max);
    end else if (push < longint'(speed_min)) begin
      v = -longint'(speed_min);
    end else begin
      v = -push;
    end
    cmd.speed = SpeedW'(v);
    cmd.status = StatusMoving;
    return cmd;
  endfunction

  always @(posedge clk_i) begin : check_commands
    speed_cmd_t want;
    if (rst_ni && out_rsp.valid && out_rsp.ready) begin
      if (expected_cmds.size() == 0) begin
        log_failure($sformatf("unexpected command: speed %0d status %0d",
                              out_rsp.linear_speed, out_rsp.status));
      end else begin
        want = expected_cmds.pop_front();
        if (out_rsp.linear_speed !== want.speed)
          log_failure($sformatf("speed mismatch: expected %0d, got %0d",
                                want.speed, out_rsp.linear_speed));
        if (out_rsp.status !== want.status)
          log_failure($sformatf("status mismatch: expected %0d, got %0d",
                                want.status, out_rsp.status));
      end
    end
  end

  function automatic pose_t make_pose(longint rx, longint ry, longint hc, longint hs,
                                      longint gx, longint gy);
    pose_t p;
    p.robot_x = PosW'(rx);
    p.robot_y = PosW'(ry);
    p.heading_cos = HeadW'(hc);
    p.heading_sin = HeadW'(hs);
    p.goal_x = PosW'(gx);
    p.goal_y = PosW'(gy);
    return p;
  endfunction

  function automatic longint rand_pos();
    return longint'($signed($urandom)) >>> 1;
  endfunction

  function automatic longint rand_head();
    return longint'($urandom_range(0, 32768)) - HeadOne;
  endfunction

  task automatic send_pose(input pose_t p);
    int gap;
    speed_cmd_t cmd;
    if ($urandom_range(99) < tx_idle_pct) begin
      gap = ($urandom_range(15) == 0) ? $urandom_range(5, 60) : $urandom_range(1, 4);
      in_req.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_req.valid <= 1'b1;
    in_req.robot_x <= p.robot_x;
    in_req.robot_y <= p.robot_y;
    in_req.heading_cos <= p.heading_cos;
    in_req.heading_sin <= p.heading_sin;
    in_req.goal_x <= p.goal_x;
    in_req.goal_y <= p.goal_y;
    @(posedge clk_i);
    while (!in_req.ready) @(posedge clk_i);
    cmd = compute_speed_command(p);
    expected_cmds.insert(expected_cmds.size(), cmd);
  endtask

  task automatic wait_drained();
    in_req.valid <= 1'b0;
    while (expected_cmds.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic program_regs(logic [CfgW-1:0] g, logic [CfgW-1:0] vmax,
                              logic [CfgW-1:0] vmin, logic [CfgW-1:0] tol);
    cfg_we <= 1'b1;
    cfg_idx <= RegGain;
    cfg_wdata <= g;
    @(posedge clk_i);
    cfg_idx <= RegMaxSpeed;
    cfg_wdata <= vmax;
    @(posedge clk_i);
    cfg_idx <= RegMinSpeed;
    cfg_wdata <= vmin;
    @(posedge clk_i);
    cfg_idx <= RegStopTol;
    cfg_wdata <= tol;
    @(posedge clk_i);
    cfg_we <= 1'b0;
    kp_gain = g;
    speed_max = vmax;
    speed_min = vmin;
    reach_tol = tol;
  endtask

  task automatic test_default_gains();
    send_pose(make_pose(0, 0, HeadOne, 0, 0, 0));
    send_pose(make_pose(0, 0, HeadOne, 0, 2 * Meter, 0));
    send_pose(make_pose(3 * Meter / 2, 0, HeadOne, 0, 2 * Meter, 0));
    // Passing the goal flips the sign against the last moving step.
    send_pose(make_pose(5 * Meter / 2, 0, HeadOne, 0, 2 * Meter, 0));
    send_pose(make_pose(5 * Meter / 2, 0, HeadOne, 0, 2 * Meter, 0));
    send_pose(make_pose(5 * Meter, 0, HeadOne, 0, 2 * Meter, 0));
    send_pose(make_pose(2 * Meter + 6553, 0, HeadOne, 0, 2 * Meter, 0));
    send_pose(make_pose(Meter, 0, 0, 0, 2 * Meter, 0));
    send_pose(make_pose(Meter, 0, 0, HeadOne, 2 * Meter, 0));
    send_pose(make_pose(2 * Meter - 655, 0, HeadOne, 0, 2 * Meter, 0));
    send_pose(make_pose(2 * Meter - 654, 0, HeadOne, 0, 2 * Meter, 0));
    send_pose(make_pose(0, 0, 3, -2, Meter, Meter));
    send_pose(make_pose(PosMin, PosMin, -HeadOne, -HeadOne, PosMax, PosMax));
    send_pose(make_pose(PosMax, PosMax, -HeadOne, 0, PosMin, PosMin));
    // Equal and opposite offsets on a diagonal heading give an exactly zero projection.
    send_pose(make_pose(PosMax, PosMin, HeadOne, HeadOne, PosMin, PosMax));
  endtask

  task automatic test_register_extremes();
    wait_drained();
    program_regs('0, '1, '0, '0);
    send_pose(make_pose(5 * Meter, 5 * Meter, HeadOne, 0, 5 * Meter, 5 * Meter));
    send_pose(make_pose(0, 0, HeadOne, 0, Meter, 0));
    send_pose(make_pose(Meter, 0, HeadOne, 0, 0, 0));
    send_pose(make_pose(Meter, 0, HeadOne, 0, 0, 0));
    wait_drained();
    // Minimum above maximum, with a tolerance far beyond a meter.
    program_regs('1, 24'd1000, '1, '1);
    send_pose(make_pose(0, 0, HeadOne, 0, Meter, 0));
    send_pose(make_pose(0, 0, HeadOne, 0, 300 * Meter, 0));
    send_pose(make_pose(300 * Meter, 0, HeadOne, 0, 0, 0));
    send_pose(make_pose(300 * Meter, 0, HeadOne, 0, 0, 0));
    wait_drained();
    program_regs('1, '1, 24'd1, 24'd1);
    send_pose(make_pose(300 * Meter, 0, HeadOne, 0, 0, 0));
    send_pose(make_pose(1, 0, HeadOne, 0, 0, 0));
    send_pose(make_pose(0, 0, HeadOne, 0, 1, 0));
  endtask

  task automatic test_random_approach();
    int sent;
    int steps;
    bit backing;
    longint gx;
    longint gy;
    longint hc;
    longint hs;
    longint span;
    longint dir;
    longint ox;
    longint oy;
    pose_t p;
    logic [CfgW-1:0] g;
    logic [CfgW-1:0] vmax;
    logic [CfgW-1:0] vmin;
    logic [CfgW-1:0] tol;
    for (int seg = 0; seg < 6; seg++) begin
      wait_drained();
      case (seg / 2)
        0: begin
          tx_idle_pct = 17;
          rx_idle_pct = 62;
        end
        1: begin
          tx_idle_pct = 62;
          rx_idle_pct = 17;
        end
        default: begin
          tx_idle_pct = 0;
          rx_idle_pct = 0;
        end
      endcase
      g = CfgW'($urandom_range(0, 2 * Meter));
      vmax = CfgW'($urandom_range(0, Meter));
      vmin = CfgW'($urandom_range(0, Meter / 4));
      tol = CfgW'($urandom_range(0, Meter / 10));
      // Odd segments push some registers across their whole range.
      if (seg % 2 == 1) begin
        if ($urandom_range(1)) g = CfgW'($urandom);
        if ($urandom_range(1)) vmax = CfgW'($urandom);
        if ($urandom_range(1)) vmin = CfgW'($urandom);
        if ($urandom_range(3) == 0) tol = CfgW'($urandom);
      end
      program_regs(g, vmax, vmin, tol);
      sent = 0;
      while (sent < SegmentItems) begin
        if ($urandom_range(4) == 0) begin
          p = make_pose(rand_pos(), rand_pos(), rand_head(), rand_head(), rand_pos(), rand_pos());
          if ($urandom_range(7) == 0) begin
            p.goal_x = p.robot_x;
            p.goal_y = p.robot_y;
          end
          if ($urandom_range(7) == 0) begin
            p.heading_cos = '0;
            p.heading_sin = '0;
          end
          send_pose(p);
          sent++;
        end else begin
          // An approach run: fixed heading, the robot closing in and possibly overshooting.
          if ($urandom_range(7) == 0) begin
            gx = longint'($signed($urandom)) >>> 4;
            gy = longint'($signed($urandom)) >>> 4;
          end else begin
            gx = longint'($urandom_range(0, 1 << 23)) - (1 << 22);
            gy = longint'($urandom_range(0, 1 << 23)) - (1 << 22);
          end
          hc = rand_head();
          hs = longint'(floor_root(64'(HeadOne * HeadOne - hc * hc)));
          if ($urandom_range(1)) hs = -hs;
          span = ($urandom_range(7) == 0) ? longint'($urandom_range(0, 1 << 22))
                                          : longint'($urandom_range(0, 5 * Meter));
          backing = 1'($urandom_range(1));
          dir = backing ? 1 : -1;
          steps = $urandom_range(3, 12);
          repeat (steps) begin
            ox = (hc * span) >>> 14;
            oy = (hs * span) >>> 14;
            send_pose(make_pose(gx + dir * ox + longint'($urandom_range(0, 64)) - 32,
                                gy + dir * oy + longint'($urandom_range(0, 64)) - 32,
                                hc, hs, gx, gy));
            span -= longint'($urandom_range(0, int'((span < 0 ? -span : span) / 3) + 3000));
            sent++;
          end
        end
      end
    end
  endtask

  initial begin
    cfg_we = 1'b0;
    cfg_idx = RegGain;
    cfg_wdata = '0;
    in_req.valid = 1'b0;
    in_req.robot_x = '0;
    in_req.robot_y = '0;
    in_req.heading_cos = '0;
    in_req.heading_sin = '0;
    in_req.goal_x = '0;
    in_req.goal_y = '0;
    tx_idle_pct = 17;
    rx_idle_pct = 62;
    kp_gain = GainReset;
    speed_max = MaxSpeedReset;
    speed_min = MinSpeedReset;
    reach_tol = StopTolReset;
    last_signed_span = '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_default_gains();
    test_register_extremes();
    test_random_approach();
    wait_drained();
    repeat (60) @(posedge clk_i);
    if (expected_cmds.size() != 0)
      log_failure($sformatf("%0d commands never arrived", expected_cmds.size()));
    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// ===== dock_approach_velocity_control_unit.f =====
rtl/dvc_pkg.sv
rtl/dvc_if.sv
rtl/dvc_mul.sv
rtl/dvc_isqrt.sv
rtl/dock_approach_velocity_control_unit.sv
verif/dock_approach_velocity_control_unit_test.sv
